// ===== sv/black_to_alpha_pixel_defines.svh =====
// Assertion macros for the file that checks the pixel pipeline.
// Each macro expects clk and rst to be visible where it is used.
`ifndef BLACK_TO_ALPHA_PIXEL_DEFINES_SVH
`define BLACK_TO_ALPHA_PIXEL_DEFINES_SVH

// Checks that a trigger is followed by a property starting in the same cycle.
`define BTA_ASSERT_IMPL(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("black_to_alpha_pixel: check failed");

// Checks that a trigger is followed by a property starting in the next cycle.
`define BTA_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("black_to_alpha_pixel: check failed");

`endif

// ===== sv/bta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  // Channel geometry.
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int PROD_W    = 2 * CHAN_W;

  // The 8 quotient bits are split evenly over the divider stages.
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = CHAN_W / DIV_STAGES;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'hFF;

  // How an item is finished at the output.
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_BLACK = 2'd1;
  localparam logic [1:0] MODE_SCALE = 2'd2;

  // One item as it moves down the pipeline.
  typedef struct packed {
    logic                             valid;
    logic [1:0]                       mode;
    logic [CHAN_W-1:0]                divisor;
    logic [CHAN_W-1:0]                alpha;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  raw;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  rem;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  low;
  } bta_item_t;

endpackage

`default_nettype wire

// ===== sv/black_to_alpha_pixel.sv =====
// An accepted item passes the front register, the four divider stage registers and the
// output register, and then has its result on the output ports with done high.
// Throughput: one item per clock; the pipeline never stalls, so busy is only high in reset.
// The depth is set by the divider, which resolves two quotient bits in each of four stages.
// Reset (rst, synchronous, active high) clears every valid bit; no item is lost after it.
`timescale 1ns / 1ps
`default_nettype none
`include "black_to_alpha_pixel_defines.svh"

module black_to_alpha_pixel
  import bta_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CHAN_W-1:0]    in_red,
  input  wire logic [CHAN_W-1:0]    in_green,
  input  wire logic [CHAN_W-1:0]    in_blue,
  input  wire logic [CHAN_W-1:0]    in_alpha,
  output logic                      done,
  output logic [CHAN_W-1:0]         out_red,
  output logic [CHAN_W-1:0]         out_green,
  output logic [CHAN_W-1:0]         out_blue,
  output logic [CHAN_W-1:0]         out_alpha
);

  bta_item_t stage [DIV_STAGES+1];
  logic      accept;

  // The pipeline always moves, so items are refused only while in reset.
  assign busy   = rst;
  assign accept = start && !busy;

  // Maximum search and dividend setup.
  bta_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .alpha    (in_alpha),
    .item     (stage[0])
  );

  // Divider stages.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    bta_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .in_item  (stage[i]),
      .out_item (stage[i+1])
    );
  end

  // Result selection and output register.
  bta_out u_out (
    .clk   (clk),
    .rst   (rst),
    .item  (stage[DIV_STAGES]),
    .done  (done),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue),
    .alpha (out_alpha)
  );

  // An accepted item enters the front stage on the next cycle.
  `BTA_ASSERT_NEXT(a_front_loaded, accept, stage[0].valid)

  // Every accepted item comes out exactly at the pipeline latency.
  `BTA_ASSERT_IMPL(a_item_delivered, accept, ##6 done)

  // An opaque pixel always leaves with at least one channel at full scale.
  `BTA_ASSERT_IMPL(a_full_scale, accept && (in_alpha == FULL_SCALE),
                   ##6 (out_red == FULL_SCALE || out_green == FULL_SCALE ||
                        out_blue == FULL_SCALE))

endmodule

`default_nettype wire

// ===== sv/bta_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bta_front
  import bta_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [CHAN_W-1:0]    red,
  input  wire logic [CHAN_W-1:0]    green,
  input  wire logic [CHAN_W-1:0]    blue,
  input  wire logic [CHAN_W-1:0]    alpha,
  output bta_item_t                 item
);

  bta_item_t         item_next;
  logic [CHAN_W-1:0] max_rg;
  logic [CHAN_W-1:0] mx;
  logic [PROD_W-1:0] dividend [NUM_CHAN];

  // Find the largest color channel.
  always_comb begin
    max_rg = (green > red) ? green : red;
    mx     = (blue > max_rg) ? blue : max_rg;
  end

  // Form 255 * channel as (channel << 8) - channel and seed the divider.
  // When the divisor is not zero, the upper byte is below it, so only 8 quotient bits remain.
  always_comb begin
    item_next.valid   = in_valid && !rst;
    item_next.divisor = mx;
    item_next.raw     = {blue, green, red};
    dividend[0]       = {red, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, red};
    dividend[1]       = {green, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, green};
    dividend[2]       = {blue, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, blue};
    for (int c = 0; c < NUM_CHAN; c++) begin
      item_next.rem[c] = dividend[c][PROD_W-1:CHAN_W];
      item_next.low[c] = dividend[c][CHAN_W-1:0];
    end
    if (alpha != FULL_SCALE) begin
      item_next.mode  = MODE_PASS;
      item_next.alpha = alpha;
    end else if (mx == '0) begin
      item_next.mode  = MODE_BLACK;
      item_next.alpha = '0;
    end else begin
      item_next.mode  = MODE_SCALE;
      item_next.alpha = mx;
    end
  end

  // Stage register; the valid bit is cleared in reset, the data is not.
  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

`default_nettype wire

// ===== sv/bta_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bta_div_stage
  import bta_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire bta_item_t  in_item,
  output bta_item_t       out_item
);

  bta_item_t         item_next;
  logic [CHAN_W:0]   trial;
  logic [CHAN_W:0]   diff;
  logic              qbit;

  // Restoring division: two quotient bits per stage for all three channels.
  // Quotient bits shift into the low byte as the dividend bits shift out.
  always_comb begin
    item_next = in_item;
    trial     = '0;
    diff      = '0;
    qbit      = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
        trial = {item_next.rem[c], item_next.low[c][CHAN_W-1]};
        diff  = trial - {1'b0, item_next.divisor};
        qbit  = (trial >= {1'b0, item_next.divisor});
        item_next.low[c] = {item_next.low[c][CHAN_W-2:0], qbit};
        item_next.rem[c] = qbit ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
      end
    end
    item_next.valid = in_item.valid && !rst;
  end

  // Stage register; the valid bit is cleared in reset, the data is not.
  always_ff @(posedge clk) begin
    out_item <= item_next;
  end

endmodule

`default_nettype wire

// ===== sv/bta_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bta_out
  import bta_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bta_item_t          item,
  output logic                    done,
  output logic [CHAN_W-1:0]       red,
  output logic [CHAN_W-1:0]       green,
  output logic [CHAN_W-1:0]       blue,
  output logic [CHAN_W-1:0]       alpha
);

  logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_next;

  // Pick the finished colors according to how the item was classified.
  always_comb begin
    case (item.mode)
      MODE_PASS:  rgb_next = item.raw;
      MODE_BLACK: rgb_next = {NUM_CHAN{FULL_SCALE}};
      MODE_SCALE: rgb_next = item.low;
      default:    rgb_next = item.raw;
    endcase
  end

  // Output register; the strobe is reset, the pixel is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item.valid;
    end
    red   <= rgb_next[0];
    green <= rgb_next[1];
    blue  <= rgb_next[2];
    alpha <= item.alpha;
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bta_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 60;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 50000;

  // One RGBA8 pixel, used for both the input item and the result.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // Predicts the keyed pixel for each accepted item and checks results in order.
  class alpha_key_scoreboard;
    rgba_t keyed_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    // Scales a channel so that the peak channel maps to full scale.
    function logic [CHAN_W-1:0] scale_to_peak(logic [CHAN_W-1:0] ch, logic [CHAN_W-1:0] peak);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quot;
      prod = PROD_W'(FULL_SCALE) * PROD_W'(ch);
      quot = prod / PROD_W'(peak);
      return quot[CHAN_W-1:0];
    endfunction

    // Black becomes transparency; pixels that are not opaque pass through.
    function rgba_t key_black(rgba_t px);
      logic [CHAN_W-1:0] peak;
      rgba_t             res;
      if (px.alpha != FULL_SCALE) return px;
      peak = px.red;
      if (px.green > peak) peak = px.green;
      if (px.blue > peak) peak = px.blue;
      if (peak == '0) begin
        res.red   = FULL_SCALE;
        res.green = FULL_SCALE;
        res.blue  = FULL_SCALE;
        res.alpha = '0;
      end else begin
        res.red   = scale_to_peak(px.red, peak);
        res.green = scale_to_peak(px.green, peak);
        res.blue  = scale_to_peak(px.blue, peak);
        res.alpha = peak;
      end
      return res;
    endfunction

    function void note_pixel(rgba_t px);
      keyed_q = {keyed_q, key_black(px)};
    endfunction

    function int pending();
      return keyed_q.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string field, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_pixel(rgba_t got);
      rgba_t want;
      if (keyed_q.size() == 0) begin
        report("result arrived with no item outstanding");
      end else begin
        want = keyed_q.pop_front();
        compare_field("out_red", got.red, want.red);
        compare_field("out_green", got.green, want.green);
        compare_field("out_blue", got.blue, want.blue);
        compare_field("out_alpha", got.alpha, want.alpha);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;
  logic [CHAN_W-1:0] in_alpha;
  logic              done;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;

  alpha_key_scoreboard sb;
  int                  accepted_items = 0;
  int                  cycles = 0;

  black_to_alpha_pixel i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watch both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_pixel('{in_red, in_green, in_blue, in_alpha});
      accepted_items++;
    end
    if (!rst && done)
      sb.check_pixel('{out_red, out_green, out_blue, out_alpha});
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one item from a falling edge and holds it until it is taken.
  task automatic send_pixel(rgba_t px);
    int seen;
    seen = accepted_items;
    start    <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    in_alpha <= px.alpha;
    do @(negedge clk); while (accepted_items == seen);
  endtask

  // Lowers start with junk on the data lines.
  task automatic idle_for(int n);
    start    <= 1'b0;
    in_red   <= CHAN_W'($urandom);
    in_green <= CHAN_W'($urandom);
    in_blue  <= CHAN_W'($urandom);
    in_alpha <= CHAN_W'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic rgba_t random_pixel();
    rgba_t px;
    int    shape;
    logic [CHAN_W-1:0] v;
    shape     = $urandom_range(0, 9);
    px.red    = CHAN_W'($urandom);
    px.green  = CHAN_W'($urandom);
    px.blue   = CHAN_W'($urandom);
    px.alpha  = FULL_SCALE;
    case (shape)
      5: begin
        // Near-black opaque pixels, black itself included.
        px.red   = CHAN_W'($urandom_range(0, 3));
        px.green = CHAN_W'($urandom_range(0, 3));
        px.blue  = CHAN_W'($urandom_range(0, 3));
      end
      6: begin
        v = CHAN_W'($urandom);
        px.red   = v;
        px.green = v;
        px.blue  = v;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: px.red = FULL_SCALE;
          1: px.green = FULL_SCALE;
          default: px.blue = FULL_SCALE;
        endcase
      end
      8, 9: px.alpha = CHAN_W'($urandom_range(0, 254));
      default: ;
    endcase
    return px;
  endfunction

  rgba_t directed_q[$];

  initial begin
    sb       = new();
    start    = 1'b0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    in_alpha = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items: field extremes and each special case.
    directed_q = '{
      '{8'd0,   8'd0,   8'd0,   8'd255},  // opaque black
      '{8'd255, 8'd255, 8'd255, 8'd255},  // opaque white
      '{8'd1,   8'd1,   8'd1,   8'd255},  // darkest grey
      '{8'd128, 8'd128, 8'd128, 8'd255},  // mid grey
      '{8'd255, 8'd0,   8'd0,   8'd255},
      '{8'd0,   8'd255, 8'd0,   8'd255},
      '{8'd0,   8'd0,   8'd255, 8'd255},
      '{8'd0,   8'd1,   8'd0,   8'd255},
      '{8'd1,   8'd0,   8'd1,   8'd255},
      '{8'd1,   8'd255, 8'd254, 8'd255},
      '{8'd3,   8'd7,   8'd5,   8'd255},
      '{8'd254, 8'd253, 8'd1,   8'd255},
      '{8'd100, 8'd200, 8'd150, 8'd255},
      '{8'd0,   8'd0,   8'd0,   8'd0},    // transparent black passes
      '{8'd255, 8'd255, 8'd255, 8'd0},
      '{8'd12,  8'd34,  8'd56,  8'd254},  // almost opaque passes
      '{8'd170, 8'd85,  8'd170, 8'd128},
      '{8'd0,   8'd0,   8'd0,   8'd254},
      '{8'd255, 8'd0,   8'd255, 8'd1}
    };
    foreach (directed_q[k]) begin
      if (k % 5 == 4) idle_for(k % 4 + 1);
      send_pixel(directed_q[k]);
    end

    // Random items; halfway through the sender waits for the pipeline to empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_until_drained();
      if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 4));
      send_pixel(random_pixel());
    end

    wait_until_drained();
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== black_to_alpha_pixel.f =====
+incdir+sv
sv/bta_pkg.sv
sv/bta_front.sv
sv/bta_div_stage.sv
sv/bta_out.sv
sv/black_to_alpha_pixel.sv
verif/testbench.sv
